// File: src/npyhdr_pkg.sv
// Shared types, character codes and match tables for the header dictionary parser.
// No dependencies; every other file of the block except npyhdr_dim_digit imports this package.
package npyhdr_pkg;

   // Parse phases.
   localparam logic [1:0] PH_WAIT  = 2'd0;
   localparam logic [1:0] PH_KEY   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // Which key the current entry belongs to.
   localparam logic [1:0] KEY_NONE  = 2'd0;
   localparam logic [1:0] KEY_DESCR = 2'd1;
   localparam logic [1:0] KEY_SHAPE = 2'd2;

   // Element kinds reported on the result channel.
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_I8      = 2'd1;
   localparam logic [1:0] KIND_F8      = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LESS   = 8'h3C;

   // Result fields have fixed widths.
   localparam int unsigned OUT_DIM_W = 31;
   localparam logic [OUT_DIM_W-1:0] OUT_DIM_MAX = {OUT_DIM_W{1'b1}};

   typedef struct packed {
      logic                 dict_closed;
      logic                 cols_given;
      logic                 rows_given;
      logic [OUT_DIM_W-1:0] col_count;
      logic [OUT_DIM_W-1:0] row_count;
      logic [1:0]           element_kind;
   } rsp_item_type;

   function automatic logic [7:0] descr_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h64; // d
         3'd1:    ch = 8'h65; // e
         3'd2:    ch = 8'h73; // s
         3'd3:    ch = 8'h63; // c
         3'd4:    ch = 8'h72; // r
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] shape_key_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h73; // s
         3'd1:    ch = 8'h68; // h
         3'd2:    ch = 8'h61; // a
         3'd3:    ch = 8'h70; // p
         3'd4:    ch = 8'h65; // e
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] i8_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CH_LESS;
         2'd1:    ch = 8'h69; // i
         2'd2:    ch = 8'h38; // 8
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] f8_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CH_LESS;
         2'd1:    ch = 8'h66; // f
         2'd2:    ch = 8'h38; // 8
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: src/npyhdr_dim_digit.sv
// Decimal digit step for a shape dimension: acc * 10 + digit, saturating.
// Depends on nothing but its parameter.
module npyhdr_dim_digit #(
   parameter int unsigned DIM_BITS = 31
) (
   input  logic [DIM_BITS-1:0] acc,
   input  logic [3:0]          digit,
   output logic [DIM_BITS-1:0] acc_next
);
   localparam int unsigned WIDE_W = DIM_BITS + 4;

   logic [WIDE_W-1:0] acc_wide;
   logic [WIDE_W-1:0] times_ten;
   logic [WIDE_W-1:0] dim_max_wide;

   // Shifts and adds form the times-ten product; it never overflows WIDE_W.
   assign acc_wide     = {4'b0000, acc};
   assign dim_max_wide = {4'b0000, {DIM_BITS{1'b1}}};
   assign times_ten    = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_W-4){1'b0}}, digit};
   assign acc_next     = (times_ten > dim_max_wide) ? {DIM_BITS{1'b1}}
                                                    : times_ten[DIM_BITS-1:0];
endmodule

// File: src/npyhdr_rsp_stage.sv
// Result register of the parser with its valid flag and stream handshake.
// Depends on npyhdr_pkg for the result item type.
module npyhdr_rsp_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  npyhdr_pkg::rsp_item_type item,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output npyhdr_pkg::rsp_item_type rsp_item,
   output logic                     full
);
   import npyhdr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Full means a result is held that will not leave at this edge.
   assign full       = valid_ff & ~rsp_tready;
   assign valid_in   = load | full;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end
endmodule

// File: src/npy_header_dict_parser.sv
// Top level of the header dictionary parser: input register, parse state and result stage.
// Depends on npyhdr_pkg, npyhdr_dim_digit and npyhdr_rsp_stage.
//
//   channel | direction | tdata                       | tlast      | tuser
//   req_    | in        | [7:0] header_byte           | last_byte  | -
//   rsp_    | out       | kind, rows, cols, flags     | -          | -
//
// Each accepted request is registered, then the parse logic updates the
// dictionary state from it; a request marked last also loads the result register.
// Sustained rate is one request per cycle while the input register does not stall.
// Reset is synchronous and active high and returns the parser to waiting for '{'.
// The input register only stalls while it holds a last request and the result
// register still holds an earlier result that the consumer has not taken.
module npy_header_dict_parser #(
   parameter int unsigned DIM_BITS  = 31,
   parameter int unsigned TOKEN_MAX = 99
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] header_byte
   input  logic        req_tlast,   // last_byte
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [1:0] element_kind, [32:2] row_count,
                                    // [63:33] col_count, [64] rows_given,
                                    // [65] cols_given, [66] dict_closed, [71:67] zero
);
   import npyhdr_pkg::*;

   // Position counter saturates at TOKEN_MAX, so it needs just enough bits for that.
   localparam int unsigned POS_W = $clog2(TOKEN_MAX + 1);
   // Width used when clamping a dimension to the 31-bit result field.
   localparam int unsigned SAT_W = (DIM_BITS > OUT_DIM_W) ? DIM_BITS : OUT_DIM_W;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic       in_last_ff;
   logic [7:0] in_byte_ff;
   logic       req_accept;
   logic       advance;
   logic       process;

   // Parse state.
   logic [1:0]          phase_ff,       phase_in;
   logic                paren_ff,       paren_in;
   logic [POS_W-1:0]    pos_ff,         pos_in;
   logic [1:0]          key_flags_ff,   key_flags_in;
   logic [1:0]          key_kind_ff,    key_kind_in;
   logic [1:0]          val_flags_ff,   val_flags_in;
   logic [DIM_BITS-1:0] acc_ff,         acc_in;
   logic [1:0]          dim_flags_ff,   dim_flags_in;
   logic [DIM_BITS-1:0] pend_rows_ff,   pend_rows_in;
   logic [DIM_BITS-1:0] pend_cols_ff,   pend_cols_in;
   logic [1:0]          pend_set_ff,    pend_set_in;
   logic [1:0]          held_kind_ff,   held_kind_in;
   logic [DIM_BITS-1:0] held_rows_ff,   held_rows_in;
   logic [DIM_BITS-1:0] held_cols_ff,   held_cols_in;
   logic                rows_given_ff,  rows_given_in;
   logic                cols_given_ff,  cols_given_in;

   // Parse logic.
   logic [7:0]          ch;
   logic                skip;
   logic                is_digit;
   logic                tok_full;
   logic [DIM_BITS-1:0] acc_digit;
   logic [DIM_BITS-1:0] token_dim;
   logic                do_clear;
   logic                do_pend_clear;
   logic                do_key;
   logic                do_val;
   logic [SAT_W-1:0]    rows_wide;
   logic [SAT_W-1:0]    cols_wide;
   rsp_item_type        rsp_next;
   rsp_item_type        rsp_item;
   logic                rsp_load;
   logic                rsp_full;

   // The input register moves on unless a last request would overwrite a held result.
   assign advance     = ~(in_last_ff & rsp_full);
   assign req_tready  = ~in_valid_ff | advance;
   assign req_accept  = req_tvalid & req_tready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign process     = in_valid_ff & advance;
   assign rsp_load    = process & in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   assign ch        = in_byte_ff;
   assign skip      = (ch == CH_SPACE) || (ch == CH_QUOTE);
   assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign tok_full  = pos_ff >= POS_W'(TOKEN_MAX);
   // An empty dimension token stands for 1.
   assign token_dim = dim_flags_ff[0] ? acc_ff : {{(DIM_BITS-1){1'b0}}, 1'b1};

   npyhdr_dim_digit #(
      .DIM_BITS (DIM_BITS)
   ) u_dim_digit (
      .acc      (acc_ff),
      .digit    (ch[3:0]),
      .acc_next (acc_digit)
   );

   always_comb begin
      phase_in      = phase_ff;
      paren_in      = paren_ff;
      pos_in        = pos_ff;
      key_flags_in  = key_flags_ff;
      key_kind_in   = key_kind_ff;
      val_flags_in  = val_flags_ff;
      acc_in        = acc_ff;
      dim_flags_in  = dim_flags_ff;
      pend_rows_in  = pend_rows_ff;
      pend_cols_in  = pend_cols_ff;
      pend_set_in   = pend_set_ff;
      held_kind_in  = held_kind_ff;
      held_rows_in  = held_rows_ff;
      held_cols_in  = held_cols_ff;
      rows_given_in = rows_given_ff;
      cols_given_in = cols_given_ff;
      do_clear      = 1'b0;
      do_pend_clear = 1'b0;
      do_key        = 1'b0;
      do_val        = 1'b0;

      if (process) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (ch == CH_LBRACE) begin
                  phase_in = PH_KEY;
                  do_clear = 1'b1;
               end
            end
            PH_KEY: begin
               if (ch == CH_RBRACE) begin
                  phase_in = PH_DONE;
               end else if (ch == CH_COLON) begin
                  if (pos_ff == POS_W'(5) && key_flags_ff[0]) begin
                     key_kind_in = KEY_DESCR;
                  end else if (pos_ff == POS_W'(5) && key_flags_ff[1]) begin
                     key_kind_in = KEY_SHAPE;
                  end else begin
                     key_kind_in = KEY_NONE;
                  end
                  do_pend_clear = 1'b1;
                  do_clear      = 1'b1;
                  phase_in      = PH_VALUE;
               end else if (!skip) begin
                  do_key = 1'b1;
               end
            end
            PH_VALUE: begin
               if (ch == CH_COMMA && !paren_ff) begin
                  // A comma outside parentheses commits the entry.
                  if (key_kind_ff == KEY_DESCR && pos_ff == POS_W'(3)) begin
                     if (val_flags_ff[0]) begin
                        held_kind_in = KIND_I8;
                     end else if (val_flags_ff[1]) begin
                        held_kind_in = KIND_F8;
                     end
                  end else if (key_kind_ff == KEY_SHAPE) begin
                     if (pend_set_ff[0]) begin
                        held_rows_in  = pend_rows_ff;
                        rows_given_in = 1'b1;
                     end
                     if (pend_set_ff[1]) begin
                        held_cols_in  = pend_cols_ff;
                        cols_given_in = 1'b1;
                     end
                  end
                  do_pend_clear = 1'b1;
                  do_clear      = 1'b1;
                  phase_in      = PH_KEY;
               end else if (!skip) begin
                  if (ch == CH_LPAREN) begin
                     paren_in = 1'b1;
                  end else if (ch == CH_RPAREN) begin
                     paren_in = 1'b0;
                  end
                  do_val = 1'b1;
               end
            end
            PH_DONE: begin
               // Bytes after the closing brace are ignored.
            end
         endcase
      end

      // Characters of a key or value token.
      if (do_key || do_val) begin
         if (tok_full) begin
            key_flags_in = 2'b00;
            val_flags_in = 2'b00;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (do_key) begin
               if (pos_ff >= POS_W'(5) || ch != descr_char(pos_ff[2:0])) begin
                  key_flags_in[0] = 1'b0;
               end
               if (pos_ff >= POS_W'(5) || ch != shape_key_char(pos_ff[2:0])) begin
                  key_flags_in[1] = 1'b0;
               end
            end else begin
               if (pos_ff >= POS_W'(3) || ch != i8_char(pos_ff[1:0])) begin
                  val_flags_in[0] = 1'b0;
               end
               if (pos_ff >= POS_W'(3) || ch != f8_char(pos_ff[1:0])) begin
                  val_flags_in[1] = 1'b0;
               end
               // Shape dimension parsing runs on every value token.
               if (ch == CH_LPAREN) begin
                  // Opening parenthesis leaves the dimension state alone.
               end else if (ch == CH_COMMA) begin
                  pend_rows_in   = token_dim;
                  pend_set_in[0] = 1'b1;
                  acc_in         = '0;
                  dim_flags_in   = 2'b00;
               end else if (ch == CH_RPAREN) begin
                  pend_cols_in   = token_dim;
                  pend_set_in[1] = 1'b1;
                  acc_in         = '0;
                  dim_flags_in   = 2'b00;
               end else if (is_digit && !dim_flags_ff[1]) begin
                  acc_in          = acc_digit;
                  dim_flags_in[0] = 1'b1;
               end else begin
                  dim_flags_in = 2'b11;
               end
            end
         end
      end

      if (do_pend_clear) begin
         pend_rows_in = '0;
         pend_cols_in = '0;
         pend_set_in  = 2'b00;
      end

      if (do_clear) begin
         pos_in       = '0;
         key_flags_in = 2'b11;
         val_flags_in = 2'b11;
         acc_in       = '0;
         dim_flags_in = 2'b00;
      end

      // Result built from the state as it stands after this byte.
      rows_wide = SAT_W'(held_rows_in);
      cols_wide = SAT_W'(held_cols_in);
      rsp_next.element_kind = held_kind_in;
      rsp_next.row_count    = (rows_wide > SAT_W'(OUT_DIM_MAX)) ? OUT_DIM_MAX
                                                                : rows_wide[OUT_DIM_W-1:0];
      rsp_next.col_count    = (cols_wide > SAT_W'(OUT_DIM_MAX)) ? OUT_DIM_MAX
                                                                : cols_wide[OUT_DIM_W-1:0];
      rsp_next.rows_given   = rows_given_in;
      rsp_next.cols_given   = cols_given_in;
      rsp_next.dict_closed  = (phase_in == PH_DONE);

      // The last byte of a header sends the parser back to its reset state.
      if (rsp_load) begin
         phase_in      = PH_WAIT;
         paren_in      = 1'b0;
         pos_in        = '0;
         key_flags_in  = 2'b11;
         key_kind_in   = KEY_NONE;
         val_flags_in  = 2'b11;
         acc_in        = '0;
         dim_flags_in  = 2'b00;
         pend_rows_in  = '0;
         pend_cols_in  = '0;
         pend_set_in   = 2'b00;
         held_kind_in  = KIND_UNKNOWN;
         held_rows_in  = '0;
         held_cols_in  = '0;
         rows_given_in = 1'b0;
         cols_given_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         paren_ff      <= 1'b0;
         pos_ff        <= '0;
         key_flags_ff  <= 2'b11;
         key_kind_ff   <= KEY_NONE;
         val_flags_ff  <= 2'b11;
         acc_ff        <= '0;
         dim_flags_ff  <= 2'b00;
         pend_rows_ff  <= '0;
         pend_cols_ff  <= '0;
         pend_set_ff   <= 2'b00;
         held_kind_ff  <= KIND_UNKNOWN;
         held_rows_ff  <= '0;
         held_cols_ff  <= '0;
         rows_given_ff <= 1'b0;
         cols_given_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         paren_ff      <= paren_in;
         pos_ff        <= pos_in;
         key_flags_ff  <= key_flags_in;
         key_kind_ff   <= key_kind_in;
         val_flags_ff  <= val_flags_in;
         acc_ff        <= acc_in;
         dim_flags_ff  <= dim_flags_in;
         pend_rows_ff  <= pend_rows_in;
         pend_cols_ff  <= pend_cols_in;
         pend_set_ff   <= pend_set_in;
         held_kind_ff  <= held_kind_in;
         held_rows_ff  <= held_rows_in;
         held_cols_ff  <= held_cols_in;
         rows_given_ff <= rows_given_in;
         cols_given_ff <= cols_given_in;
      end
   end

   npyhdr_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .item       (rsp_next),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item),
      .full       (rsp_full)
   );

   assign rsp_tdata = {5'b00000,
                       rsp_item.dict_closed,
                       rsp_item.cols_given,
                       rsp_item.rows_given,
                       rsp_item.col_count,
                       rsp_item.row_count,
                       rsp_item.element_kind};
endmodule

// File: src/npyhdr_checker.sv
// Port-level checks on the result channel of the header dictionary parser.
// Depends on npyhdr_pkg and on npy_header_dict_parser, to which the bind at the end attaches it.
module npyhdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import npyhdr_pkg::*;

   // A result waiting on the consumer stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result appears in the cycle after a reset edge.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The element kind is one of the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == KIND_UNKNOWN || rsp_tdata[1:0] == KIND_I8 ||
                      rsp_tdata[1:0] == KIND_F8))
      else $error("undefined element kind");

   // A dimension that was never committed reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[64] || rsp_tdata[32:2] == '0) &&
                     (rsp_tdata[65] || rsp_tdata[63:33] == '0))
      else $error("dimension without its given flag");

   // Padding bits stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:67] == 5'b00000)
      else $error("nonzero padding in result");
endmodule

bind npy_header_dict_parser npyhdr_checker u_npyhdr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
